// File: design/r5sam_pkg.sv
// ----------------------------------------------------------------------------
// r5sam_pkg
// Shared types and constants for the RAID-5 stripe address map: payload
// structs, configuration register indexes, controller states and the
// command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package r5sam_pkg;

    localparam int CHUNK_BYTES = 512;
    localparam int CHUNK_BITS  = $clog2(CHUNK_BYTES);
    localparam int MAX_DISKS   = 16;
    localparam int MAX_PIECES  = 64;

    localparam int OFF_W    = 32;
    localparam int LEN_W    = 32;
    localparam int CAP_W    = 32;
    localparam int NDISK_W  = 5;
    localparam int DISK_W   = 4;
    localparam int LAYER_W  = 23;
    localparam int PLEN_W   = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // chunk index of a non-negative offset
    localparam int SLIDE_W    = OFF_W - 1 - CHUNK_BITS;
    localparam int REST_LIMIT = (MAX_PIECES - 1) * CHUNK_BYTES;
    localparam int REST_W     = $clog2(REST_LIMIT + 1);
    localparam int DIV_CNT_W  = $clog2(SLIDE_W + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISK_COUNT     = 2'd0,
        CFG_ARRAY_CAPACITY = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic signed [OFF_W-1:0] byte_offset;
        logic [LEN_W-1:0]        byte_length;
    } in_item_t;

    typedef struct packed {
        logic [DISK_W-1:0]  disk_index;
        logic [31:0]        disk_byte_offset;
        logic [LAYER_W-1:0] stripe_layer;
        logic [PLEN_W-1:0]  piece_length;
        logic               last_piece;
        logic               range_error;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_LAYER,
        ST_DIV_PARITY,
        ST_EMIT,
        ST_ERROR
    } state_t;

    typedef struct packed {
        logic load;        // capture the request
        logic setup;       // capture first piece geometry
        logic div_start;   // launch the shared divider
        logic div_sel;     // 0: chunk / (n-1), 1: layer % n
        logic take_layer;  // capture layer and data slot
        logic take_parity; // capture parity disk
        logic emit;        // load next piece into the output register
        logic emit_err;    // load an error result
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic div_done;
        logic out_free;
        logic last;
    } status_t;

endpackage

// File: design/r5sam_div.sv
// ----------------------------------------------------------------------------
// r5sam_div
// Restoring divider, one quotient bit per cycle, for a chunk or layer number
// over a small disk count. Gives quotient and remainder with a done pulse.
// ----------------------------------------------------------------------------
module r5sam_div
    import r5sam_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SLIDE_W-1:0] dividend,
    input  logic [NDISK_W-1:0] divisor,
    output logic               done,
    output logic [SLIDE_W-1:0] quotient,
    output logic [NDISK_W-1:0] remainder
);

    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic                 done_reg, done_next;
    logic [SLIDE_W-1:0]   quot_reg, quot_next;
    logic [NDISK_W-1:0]   rem_reg, rem_next;
    logic [NDISK_W-1:0]   div_reg, div_next;
    logic [NDISK_W:0]     shifted;
    logic [NDISK_W:0]     diff;
    logic                 ge;

    always_comb
    begin
        shifted    = {rem_reg, quot_reg[SLIDE_W-1]};
        diff       = shifted - {1'b0, div_reg};
        ge         = shifted >= {1'b0, div_reg};
        count_next = count_reg;
        done_next  = 1'b0;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        if (start)
        begin
            count_next = DIV_CNT_W'(SLIDE_W);
            quot_next  = dividend;
            rem_next   = '0;
            div_next   = divisor;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - 1'b1;
            done_next  = (count_reg == DIV_CNT_W'(1));
            quot_next  = {quot_reg[SLIDE_W-2:0], ge};
            rem_next   = ge ? diff[NDISK_W-1:0] : shifted[NDISK_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

// File: design/r5sam_dpath.sv
// ----------------------------------------------------------------------------
// r5sam_dpath
// Datapath: configuration registers, request checks, piece geometry, the
// shared divider and the output register.
// ----------------------------------------------------------------------------
module r5sam_dpath
    import r5sam_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_item_t              in_data,
    input  logic                  out_ready,
    output logic                  out_valid,
    output out_item_t             out_data,
    input  cmd_t                  cmd,
    output status_t               status
);

    logic [NDISK_W-1:0] disk_count_reg;
    logic [CAP_W-1:0]   array_capacity_reg;

    logic [OFF_W-1:0]      off_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [CHUNK_BITS-1:0] chunk_ofs_reg;
    logic [PLEN_W-1:0]     first_reg;
    logic [REST_W-1:0]     rest_reg;
    logic                  first_flag_reg;
    logic [LAYER_W-1:0]    layer_reg;
    logic [DISK_W-1:0]     slot_reg;
    logic [DISK_W-1:0]     parity_reg;
    logic                  out_valid_reg;
    out_item_t             out_data_reg;

    logic [CHUNK_BITS-1:0] chunk_ofs;
    logic [PLEN_W-1:0]     room;
    logic [PLEN_W-1:0]     first;
    logic [LEN_W-1:0]      rest;
    logic [LEN_W:0]        end_sum;
    logic                  bad;

    logic               div_start;
    logic [SLIDE_W-1:0] div_dividend;
    logic [NDISK_W-1:0] div_divisor;
    logic               div_done;
    logic [SLIDE_W-1:0] div_quot;
    logic [NDISK_W-1:0] div_rem;

    logic [PLEN_W-1:0]  take;
    logic [REST_W-1:0]  remaining;
    logic [DISK_W-1:0]  disk;
    logic [31:0]        doff;
    logic               slot_wrap;
    logic               parity_wrap;
    logic               out_free;
    out_item_t          piece;
    out_item_t          err_piece;

    // request checks
    always_comb
    begin
        chunk_ofs = off_reg[CHUNK_BITS-1:0];
        room      = PLEN_W'(CHUNK_BYTES) - PLEN_W'(chunk_ofs);
        first     = (len_reg < LEN_W'(room)) ? len_reg[PLEN_W-1:0] : room;
        rest      = len_reg - LEN_W'(first);
        end_sum   = {1'b0, off_reg} + {1'b0, len_reg};
        bad       = (disk_count_reg < NDISK_W'(2))
                 || (disk_count_reg > NDISK_W'(MAX_DISKS))
                 || off_reg[OFF_W-1]
                 || (end_sum > {1'b0, array_capacity_reg})
                 || (rest > LEN_W'(REST_LIMIT));
    end

    always_comb
    begin
        div_start    = cmd.div_start;
        div_dividend = cmd.div_sel ? div_quot : off_reg[OFF_W-2:CHUNK_BITS];
        div_divisor  = cmd.div_sel ? disk_count_reg : disk_count_reg - 1'b1;
    end

    r5sam_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // piece geometry
    always_comb
    begin
        if (first_flag_reg)
        begin
            take      = first_reg;
            remaining = rest_reg;
        end
        else
        begin
            take      = (rest_reg < REST_W'(CHUNK_BYTES)) ? PLEN_W'(rest_reg)
                                                          : PLEN_W'(CHUNK_BYTES);
            remaining = rest_reg - REST_W'(take);
        end
        disk = slot_reg + DISK_W'(slot_reg >= parity_reg);
        doff = {layer_reg, (first_flag_reg ? chunk_ofs_reg : CHUNK_BITS'(0))};
        slot_wrap   = ({1'b0, slot_reg} + 1'b1) == (disk_count_reg - 1'b1);
        parity_wrap = ({1'b0, parity_reg} + 1'b1) == disk_count_reg;

        piece                  = '0;
        piece.disk_index       = disk;
        piece.disk_byte_offset = doff;
        piece.stripe_layer     = layer_reg;
        piece.piece_length     = take;
        piece.last_piece       = (remaining == '0);

        err_piece             = '0;
        err_piece.range_error = 1'b1;
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_count_reg     <= NDISK_W'(3);
            array_capacity_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wen && (cfg_index == CFG_DISK_COUNT))
                disk_count_reg <= cfg_data[NDISK_W-1:0];
            if (cfg_wen && (cfg_index == CFG_ARRAY_CAPACITY))
                array_capacity_reg <= cfg_data[CAP_W-1:0];
            if (cmd.emit || cmd.emit_err)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            off_reg <= in_data.byte_offset;
            len_reg <= in_data.byte_length;
        end
        if (cmd.setup)
        begin
            chunk_ofs_reg  <= chunk_ofs;
            first_reg      <= first;
            rest_reg       <= rest[REST_W-1:0];
            first_flag_reg <= 1'b1;
        end
        if (cmd.take_layer)
        begin
            layer_reg <= LAYER_W'(div_quot);
            slot_reg  <= div_rem[DISK_W-1:0];
        end
        if (cmd.take_parity)
            parity_reg <= div_rem[DISK_W-1:0];
        if (cmd.emit)
        begin
            out_data_reg   <= piece;
            first_flag_reg <= 1'b0;
            rest_reg       <= remaining;
            if (slot_wrap)
            begin
                slot_reg   <= '0;
                layer_reg  <= layer_reg + 1'b1;
                parity_reg <= parity_wrap ? DISK_W'(0) : parity_reg + 1'b1;
            end
            else
                slot_reg <= slot_reg + 1'b1;
        end
        else if (cmd.emit_err)
            out_data_reg <= err_piece;
    end

    always_comb
    begin
        status.bad      = bad;
        status.div_done = div_done;
        status.out_free = out_free;
        status.last     = piece.last_piece;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: design/r5sam_ctrl.sv
// ----------------------------------------------------------------------------
// r5sam_ctrl
// Controller: sequences check, the two divisions and piece emission (or one
// error result) for one request at a time.
// ----------------------------------------------------------------------------
module r5sam_ctrl
    import r5sam_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output cmd_t    cmd,
    input  status_t status
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.setup = 1'b1;
                if (status.bad)
                    state_next = ST_ERROR;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_LAYER;
                end
            end
            ST_DIV_LAYER:
            begin
                if (status.div_done)
                begin
                    cmd.take_layer = 1'b1;
                    cmd.div_start  = 1'b1;
                    cmd.div_sel    = 1'b1;
                    state_next     = ST_DIV_PARITY;
                end
            end
            ST_DIV_PARITY:
            begin
                if (status.div_done)
                begin
                    cmd.take_parity = 1'b1;
                    state_next      = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last)
                        state_next = ST_IDLE;
                end
            end
            ST_ERROR:
            begin
                if (status.out_free)
                begin
                    cmd.emit_err = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/raid5_stripe_address_map_core.sv
// ----------------------------------------------------------------------------
// raid5_stripe_address_map_core
// Splits a logical byte request into chunk pieces over a RAID-5 array with
// rotating parity, one result request per piece.
//
// Usage:
//   in channel  : byte offset and length, taken when in_valid and in_ready.
//   out channel : one piece per request moved, last_piece on the final one;
//                 a bad request gives a single result with range_error set.
//   cfg port    : disk_count (index 0) and array_capacity (index 1), written
//                 while no request is in flight.
//   Sequence    : first piece after the check and both divider runs, then one
//                 piece per cycle while out_ready is high; errors skip the divider.
//   Throughput  : one request at a time, set by two 22-step runs of the
//                 shared restoring divider and by the number of pieces.
//   Reset       : disk_count 3, array_capacity 0, channels empty.
//   Stall       : a held output register stops emission; the next request
//                 is taken once the last piece sits in the output register.
// ----------------------------------------------------------------------------
module raid5_stripe_address_map_core
    import r5sam_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data
);

    cmd_t    cmd;
    status_t status;

    r5sam_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    r5sam_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

`ifndef NO_ASSERTIONS
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.range_error |->
            (out_data.disk_index == '0) && (out_data.disk_byte_offset == '0)
            && (out_data.stripe_layer == '0) && (out_data.piece_length == '0)
            && !out_data.last_piece)
        else $error("error result carries non-zero fields");

    a_piece_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.range_error |->
            out_data.piece_length <= PLEN_W'(CHUNK_BYTES))
        else $error("piece longer than one chunk");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in flight");
`endif

endmodule
